// File: hdl/fmc_pkg.sv
package fmc_pkg;

    localparam int DEFAULT_RULES = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam int REQ_W    = 2;
    localparam int IDX_W    = 6;
    localparam int PROTO_W  = 8;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int RPROTO_W = 2;
    localparam int COUNT_W  = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [REQ_W-1:0] REQ_CLASSIFY   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_LOW  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE_HIGH = 2'd2;

    localparam logic [PROTO_W-1:0] PROTO_NUM_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_NUM_UDP = 8'd17;

    localparam logic [RPROTO_W-1:0] RULE_ANY = 2'd0;
    localparam logic [RPROTO_W-1:0] RULE_TCP = 2'd1;
    localparam logic [RPROTO_W-1:0] RULE_UDP = 2'd2;

    localparam logic REG_INBOUND  = 1'b0;
    localparam logic REG_OUTBOUND = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE_LOW,
        CMD_WRITE_HIGH,
        CMD_SCAN,
        CMD_BYPASS
    } cmd_kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] src_l4;
        logic [PORT_W-1:0] dst_l4;
    } bounds_t;

    typedef struct packed {
        bounds_t             bounds;
        logic                enabled;
        logic                drops;
        logic [RPROTO_W-1:0] protocol;
    } upper_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                direction;
        logic [IDX_W-1:0]    rule_index;
        logic                is_tcp;
        bounds_t             fields;
        logic [RPROTO_W-1:0] rule_protocol;
        logic                rule_drops;
        logic                rule_enabled;
    } cmd_t;

endpackage

// File: hdl/fmc_if.sv
interface fmc_req_if;
    logic                             valid;
    logic                             ready;
    logic [fmc_pkg::REQ_W-1:0]        req_type;
    logic                             direction;
    logic [fmc_pkg::IDX_W-1:0]        rule_index;
    logic [fmc_pkg::PROTO_W-1:0]      ip_protocol;
    logic [fmc_pkg::ADDR_W-1:0]       source_address;
    logic [fmc_pkg::ADDR_W-1:0]       destination_address;
    logic [fmc_pkg::PORT_W-1:0]       source_port;
    logic [fmc_pkg::PORT_W-1:0]       destination_port;
    logic [fmc_pkg::RPROTO_W-1:0]     rule_protocol;
    logic                             rule_drops;
    logic                             rule_enabled;

    modport source (
        output valid, req_type, direction, rule_index, ip_protocol, source_address,
               destination_address, source_port, destination_port, rule_protocol,
               rule_drops, rule_enabled,
        input  ready
    );

    modport sink (
        input  valid, req_type, direction, rule_index, ip_protocol, source_address,
               destination_address, source_port, destination_port, rule_protocol,
               rule_drops, rule_enabled,
        output ready
    );
endinterface

interface fmc_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      verdict_drop;
    logic                      rule_matched;
    logic [fmc_pkg::IDX_W-1:0] matched_index;
    logic                      bypassed;

    modport source (
        output valid, verdict_drop, rule_matched, matched_index, bypassed,
        input  ready
    );

    modport sink (
        input  valid, verdict_drop, rule_matched, matched_index, bypassed,
        output ready
    );
endinterface

// File: hdl/first_match_packet_rule_classifier.sv
// channel   | role           | transaction
// ----------+----------------+--------------------------------------------------
// req       | sink           | classify request, or lower / upper rule write
// rsp       | source         | verdict, one per classify request
// apb       | slave          | rule counts, inbound at 0x0, outbound at 0x4
//
// classify: one rule checked per cycle by the scan over the rule memories, up to
// the direction's count capped at RULES_PER_DIRECTION; the scan stops at the first match
// bypass and rule writes are done by the back end in its idle state, without a scan
// after reset a clearing pass over all 2 * RULES_PER_DIRECTION entries zeroes rule
// attributes; req is held off until it ends
// a command queue lets the front keep taking requests while the back scans
// or while a verdict waits on rsp
module first_match_packet_rule_classifier #(
    parameter int RULES_PER_DIRECTION = fmc_pkg::DEFAULT_RULES,
    parameter int CMD_QUEUE_DEPTH     = fmc_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fmc_pkg::APB_AW-1:0]   paddr,
    input  logic [fmc_pkg::APB_DW-1:0]   pwdata,
    output logic [fmc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    fmc_req_if.sink                      req,
    fmc_rsp_if.source                    rsp
);
    import fmc_pkg::*;

    logic [COUNT_W-1:0] inbound_count_reg,  inbound_count_next;
    logic [COUNT_W-1:0] outbound_count_reg, outbound_count_next;
    logic               reg_sel;
    logic               busy;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_comb
    begin
        inbound_count_next  = inbound_count_reg;
        outbound_count_next = outbound_count_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_INBOUND:  inbound_count_next  = pwdata[COUNT_W-1:0];
                REG_OUTBOUND: outbound_count_next = pwdata[COUNT_W-1:0];
                default:      inbound_count_next  = inbound_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_INBOUND:  prdata = APB_DW'(inbound_count_reg);
            REG_OUTBOUND: prdata = APB_DW'(outbound_count_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inbound_count_reg  <= '0;
            outbound_count_reg <= '0;
        end
        else
        begin
            inbound_count_reg  <= inbound_count_next;
            outbound_count_reg <= outbound_count_next;
        end
    end

    fmc_front #(.RULES(RULES_PER_DIRECTION)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (busy),
        .req       (req),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    fmc_queue #(.DEPTH(CMD_QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_data  (back_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    fmc_back #(.RULES(RULES_PER_DIRECTION)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (back_cmd),
        .cmd_valid      (back_valid),
        .cmd_ready      (back_ready),
        .inbound_count  (inbound_count_reg),
        .outbound_count (outbound_count_reg),
        .busy           (busy),
        .rsp            (rsp)
    );
endmodule

// File: hdl/fmc_ram.sv
module fmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hdl/fmc_front.sv
module fmc_front #(
    parameter int RULES = fmc_pkg::DEFAULT_RULES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold,
    fmc_req_if.sink       req,
    output fmc_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);
    import fmc_pkg::*;

    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic valid_reg;
    logic valid_next;
    cmd_t dec;
    logic dec_valid;
    logic in_range;
    logic is_tcp;
    logic is_udp;
    logic take;

    assign req.ready = !hold && (!valid_reg || cmd_ready);
    assign take      = req.valid && req.ready;
    assign is_tcp    = (req.ip_protocol == PROTO_NUM_TCP);
    assign is_udp    = (req.ip_protocol == PROTO_NUM_UDP);
    assign in_range  = (32'(req.rule_index) < 32'(RULES));

    always_comb
    begin
        dec.kind            = CMD_SCAN;
        dec.direction       = req.direction;
        dec.rule_index      = req.rule_index;
        dec.is_tcp          = is_tcp;
        dec.fields.src_addr = req.source_address;
        dec.fields.dst_addr = req.destination_address;
        dec.fields.src_l4   = req.source_port;
        dec.fields.dst_l4   = req.destination_port;
        dec.rule_protocol   = req.rule_protocol;
        dec.rule_drops      = req.rule_drops;
        dec.rule_enabled    = req.rule_enabled;
        dec_valid           = 1'b0;
        unique case (req.req_type)
            REQ_CLASSIFY:
            begin
                dec.kind  = (is_tcp || is_udp) ? CMD_SCAN : CMD_BYPASS;
                dec_valid = 1'b1;
            end
            REQ_WRITE_LOW:
            begin
                dec.kind  = CMD_WRITE_LOW;
                dec_valid = in_range;
            end
            REQ_WRITE_HIGH:
            begin
                dec.kind  = CMD_WRITE_HIGH;
                dec_valid = in_range;
            end
            default:
            begin
                dec_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (valid_reg && cmd_ready)
        begin
            valid_next = 1'b0;
        end
        if (take && dec_valid)
        begin
            valid_next = 1'b1;
            cmd_next   = dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;
endmodule

// File: hdl/fmc_queue.sv
module fmc_queue #(
    parameter int DEPTH = fmc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fmc_pkg::cmd_t in_data,
    input  logic          in_valid,
    output logic          in_ready,
    output fmc_pkg::cmd_t out_data,
    output logic          out_valid,
    input  logic          out_ready
);
    import fmc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entries[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= in_data;
        end
    end
endmodule

// File: hdl/fmc_back.sv
module fmc_back #(
    parameter int RULES = fmc_pkg::DEFAULT_RULES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmc_pkg::cmd_t                 cmd,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [fmc_pkg::COUNT_W-1:0]   inbound_count,
    input  logic [fmc_pkg::COUNT_W-1:0]   outbound_count,
    output logic                          busy,
    fmc_rsp_if.source                     rsp
);
    import fmc_pkg::*;

    localparam int ENTRIES = 2 * RULES;
    localparam int AW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(RULES + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t           state_reg,       state_next;
    logic [AW-1:0]    clr_addr_reg,    clr_addr_next;
    logic [CW-1:0]    issue_reg,       issue_next;
    logic [CW-1:0]    limit_reg,       limit_next;
    logic             rd_valid_reg,    rd_valid_next;
    logic [CW-1:0]    rd_idx_reg,      rd_idx_next;
    logic             dir_reg,         dir_next;
    logic             tcp_reg,         tcp_next;
    bounds_t          pkt_reg,         pkt_next;
    logic             res_drop_reg,    res_drop_next;
    logic             res_matched_reg, res_matched_next;
    logic [IDX_W-1:0] res_index_reg,   res_index_next;
    logic             out_valid_reg,   out_valid_next;
    logic             out_drop_reg,    out_drop_next;
    logic             out_matched_reg, out_matched_next;
    logic [IDX_W-1:0] out_index_reg,   out_index_next;
    logic             out_bypass_reg,  out_bypass_next;

    logic          lo_we;
    logic          hi_we;
    logic [AW-1:0] waddr;
    bounds_t       lo_wdata;
    upper_t        hi_wdata;
    logic [AW-1:0] raddr;
    bounds_t       lo_rdata;
    upper_t        hi_rdata;

    logic [AW-1:0]         cmd_base;
    logic [AW-1:0]         scan_base;
    logic [COUNT_W-1:0]    count_sel;
    logic [31:0]           limit_wide;
    logic [RPROTO_W-1:0]   want;
    logic                  proto_ok;
    logic                  range_ok;
    logic                  hit;
    logic                  out_free;

    fmc_ram #(.WIDTH($bits(bounds_t)), .DEPTH(ENTRIES)) u_low_ram (
        .clk   (clk),
        .we    (lo_we),
        .waddr (waddr),
        .wdata (lo_wdata),
        .raddr (raddr),
        .rdata (lo_rdata)
    );

    fmc_ram #(.WIDTH($bits(upper_t)), .DEPTH(ENTRIES)) u_high_ram (
        .clk   (clk),
        .we    (hi_we),
        .waddr (waddr),
        .wdata (hi_wdata),
        .raddr (raddr),
        .rdata (hi_rdata)
    );

    assign cmd_base   = cmd.direction ? AW'(RULES) : '0;
    assign scan_base  = dir_reg ? AW'(RULES) : '0;
    assign raddr      = scan_base + AW'(issue_reg);
    assign count_sel  = cmd.direction ? outbound_count : inbound_count;
    assign limit_wide = (32'(count_sel) > 32'(RULES)) ? 32'(RULES) : 32'(count_sel);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign busy       = (state_reg == ST_CLEAR);

    assign want     = tcp_reg ? RULE_TCP : RULE_UDP;
    assign proto_ok = hi_rdata.enabled
                   && ((hi_rdata.protocol == RULE_ANY) || (hi_rdata.protocol == want));
    assign range_ok = (pkt_reg.src_addr >= lo_rdata.src_addr)
                   && (pkt_reg.src_addr <= hi_rdata.bounds.src_addr)
                   && (pkt_reg.dst_addr >= lo_rdata.dst_addr)
                   && (pkt_reg.dst_addr <= hi_rdata.bounds.dst_addr)
                   && (pkt_reg.src_l4 >= lo_rdata.src_l4)
                   && (pkt_reg.src_l4 <= hi_rdata.bounds.src_l4)
                   && (pkt_reg.dst_l4 >= lo_rdata.dst_l4)
                   && (pkt_reg.dst_l4 <= hi_rdata.bounds.dst_l4);
    assign hit      = rd_valid_reg && proto_ok && range_ok;

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        issue_next       = issue_reg;
        limit_next       = limit_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = issue_reg;
        dir_next         = dir_reg;
        tcp_next         = tcp_reg;
        pkt_next         = pkt_reg;
        res_drop_next    = res_drop_reg;
        res_matched_next = res_matched_reg;
        res_index_next   = res_index_reg;
        out_valid_next   = out_valid_reg;
        out_drop_next    = out_drop_reg;
        out_matched_next = out_matched_reg;
        out_index_next   = out_index_reg;
        out_bypass_next  = out_bypass_reg;

        cmd_ready          = 1'b0;
        lo_we              = 1'b0;
        hi_we              = 1'b0;
        waddr              = cmd_base + AW'(cmd.rule_index);
        lo_wdata           = cmd.fields;
        hi_wdata.bounds    = cmd.fields;
        hi_wdata.enabled   = cmd.rule_enabled;
        hi_wdata.drops     = cmd.rule_drops;
        hi_wdata.protocol  = cmd.rule_protocol;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                hi_we         = 1'b1;
                waddr         = clr_addr_reg;
                hi_wdata      = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_WRITE_LOW:
                        begin
                            cmd_ready = 1'b1;
                            lo_we     = 1'b1;
                        end
                        CMD_WRITE_HIGH:
                        begin
                            cmd_ready = 1'b1;
                            hi_we     = 1'b1;
                        end
                        CMD_BYPASS:
                        begin
                            if (out_free)
                            begin
                                cmd_ready        = 1'b1;
                                out_valid_next   = 1'b1;
                                out_drop_next    = 1'b0;
                                out_matched_next = 1'b0;
                                out_index_next   = '0;
                                out_bypass_next  = 1'b1;
                            end
                        end
                        CMD_SCAN:
                        begin
                            cmd_ready  = 1'b1;
                            dir_next   = cmd.direction;
                            tcp_next   = cmd.is_tcp;
                            pkt_next   = cmd.fields;
                            issue_next = '0;
                            limit_next = CW'(limit_wide);
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            cmd_ready = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue_reg != limit_reg)
                begin
                    rd_valid_next = 1'b1;
                    issue_next    = issue_reg + 1'b1;
                end
                if (hit)
                begin
                    rd_valid_next    = 1'b0;
                    res_drop_next    = hi_rdata.drops;
                    res_matched_next = 1'b1;
                    res_index_next   = IDX_W'(rd_idx_reg);
                    state_next       = ST_RESULT;
                end
                else if ((issue_reg == limit_reg) && !rd_valid_reg)
                begin
                    res_drop_next    = 1'b0;
                    res_matched_next = 1'b0;
                    res_index_next   = '0;
                    state_next       = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_drop_next    = res_drop_reg;
                    out_matched_next = res_matched_reg;
                    out_index_next   = res_index_reg;
                    out_bypass_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            issue_reg       <= '0;
            limit_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            dir_reg         <= 1'b0;
            tcp_reg         <= 1'b0;
            pkt_reg         <= '0;
            res_drop_reg    <= 1'b0;
            res_matched_reg <= 1'b0;
            res_index_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_drop_reg    <= 1'b0;
            out_matched_reg <= 1'b0;
            out_index_reg   <= '0;
            out_bypass_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            issue_reg       <= issue_next;
            limit_reg       <= limit_next;
            rd_valid_reg    <= rd_valid_next;
            rd_idx_reg      <= rd_idx_next;
            dir_reg         <= dir_next;
            tcp_reg         <= tcp_next;
            pkt_reg         <= pkt_next;
            res_drop_reg    <= res_drop_next;
            res_matched_reg <= res_matched_next;
            res_index_reg   <= res_index_next;
            out_valid_reg   <= out_valid_next;
            out_drop_reg    <= out_drop_next;
            out_matched_reg <= out_matched_next;
            out_index_reg   <= out_index_next;
            out_bypass_reg  <= out_bypass_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.verdict_drop  = out_drop_reg;
    assign rsp.rule_matched  = out_matched_reg;
    assign rsp.matched_index = out_index_reg;
    assign rsp.bypassed      = out_bypass_reg;
endmodule

// File: tb/verdict_checker.sv
module verdict_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fmc_pkg::APB_AW-1:0] paddr,
    input  logic [fmc_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    fmc_req_if                         req,
    fmc_rsp_if                         rsp,
    output int                         failures,
    output int                         pending_verdicts
);
    import fmc_pkg::*;

    localparam int RULES = DEFAULT_RULES;
    localparam logic [APB_AW-1:0] INBOUND_ADDR  = {REG_INBOUND, 2'b00};
    localparam logic [APB_AW-1:0] OUTBOUND_ADDR = {REG_OUTBOUND, 2'b00};

    typedef struct packed {
        logic             drop;
        logic             matched;
        logic [IDX_W-1:0] index;
        logic             bypassed;
    } verdict_t;

    bounds_t             rule_low   [2*RULES];
    bounds_t             rule_high  [2*RULES];
    logic                rule_on    [2*RULES];
    logic                rule_drops [2*RULES];
    logic [RPROTO_W-1:0] rule_proto [2*RULES];
    logic [COUNT_W-1:0]  inbound_count;
    logic [COUNT_W-1:0]  outbound_count;
    verdict_t            verdict_queue[$];
    verdict_t            oldest;
    int                  entry;

    function automatic logic covers(input logic [ADDR_W-1:0] v, lo, hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic verdict_t classify_packet(input logic dir,
                                                 input logic [PROTO_W-1:0] proto,
                                                 input bounds_t pkt);
        verdict_t            v;
        int                  limit;
        int                  slot;
        logic [RPROTO_W-1:0] wanted;
        v = '0;
        if (proto != PROTO_NUM_TCP && proto != PROTO_NUM_UDP)
        begin
            v.bypassed = 1'b1;
            return v;
        end
        limit = dir ? outbound_count : inbound_count;
        if (limit > RULES)
            limit = RULES;
        wanted = (proto == PROTO_NUM_TCP) ? RULE_TCP : RULE_UDP;
        for (int i = 0; i < limit; i++)
        begin
            slot = (dir ? RULES : 0) + i;
            if (rule_on[slot] && (rule_proto[slot] == RULE_ANY || rule_proto[slot] == wanted)
                && covers(pkt.src_addr, rule_low[slot].src_addr, rule_high[slot].src_addr)
                && covers(pkt.dst_addr, rule_low[slot].dst_addr, rule_high[slot].dst_addr)
                && covers(pkt.src_l4, rule_low[slot].src_l4, rule_high[slot].src_l4)
                && covers(pkt.dst_l4, rule_low[slot].dst_l4, rule_high[slot].dst_l4))
            begin
                v.drop    = rule_drops[slot];
                v.matched = 1'b1;
                v.index   = IDX_W'(i);
                return v;
            end
        end
        return v;
    endfunction

    task automatic check_field(input string name, input logic [7:0] expected,
                               input logic [7:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                     actual);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < 2*RULES; e++)
            begin
                rule_low[e]   = '0;
                rule_high[e]  = '0;
                rule_on[e]    = 1'b0;
                rule_drops[e] = 1'b0;
                rule_proto[e] = RULE_ANY;
            end
            inbound_count  = '0;
            outbound_count = '0;
            verdict_queue.delete();
            failures = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == INBOUND_ADDR)
                    inbound_count = pwdata[COUNT_W-1:0];
                else if (paddr == OUTBOUND_ADDR)
                    outbound_count = pwdata[COUNT_W-1:0];
            end
            if (rsp.valid && rsp.ready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $display("%0t: verdict with none expected, expected none, actual %0d %0d %0d %0d",
                             $time, rsp.verdict_drop, rsp.rule_matched, rsp.matched_index,
                             rsp.bypassed);
                    failures++;
                end
                else
                begin
                    oldest = verdict_queue.pop_front();
                    check_field("verdict_drop", oldest.drop, rsp.verdict_drop);
                    check_field("rule_matched", oldest.matched, rsp.rule_matched);
                    check_field("matched_index", oldest.index, rsp.matched_index);
                    check_field("bypassed", oldest.bypassed, rsp.bypassed);
                end
            end
            if (req.valid && req.ready)
            begin
                entry = {req.direction, req.rule_index};
                case (req.req_type)
                    REQ_WRITE_LOW:
                        rule_low[entry] = {req.source_address, req.destination_address,
                                           req.source_port, req.destination_port};
                    REQ_WRITE_HIGH:
                    begin
                        rule_high[entry]  = {req.source_address, req.destination_address,
                                             req.source_port, req.destination_port};
                        rule_on[entry]    = req.rule_enabled;
                        rule_drops[entry] = req.rule_drops;
                        rule_proto[entry] = req.rule_protocol;
                    end
                    REQ_CLASSIFY:
                        verdict_queue.push_back(classify_packet(req.direction, req.ip_protocol,
                            {req.source_address, req.destination_address,
                             req.source_port, req.destination_port}));
                    default:
                        ;
                endcase
            end
        end
        pending_verdicts <= verdict_queue.size();
    end

endmodule

// File: tb/testbench.sv
module testbench;
    import fmc_pkg::*;

    localparam int RULES            = DEFAULT_RULES;
    localparam int TOTAL_ITEMS      = 1150;
    localparam int PHASE_ITEMS      = 190;
    localparam int QUIET_ITEMS      = 100;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 20;
    localparam int DRAIN_CYCLES     = 100;
    localparam int TIMEOUT_CYCLES   = 600000;

    localparam logic                DIR_INBOUND  = 1'b0;
    localparam logic                DIR_OUTBOUND = 1'b1;
    localparam logic [REQ_W-1:0]    REQ_RESERVED = 2'd3;
    localparam logic [RPROTO_W-1:0] RULE_NEVER   = 2'd3;
    localparam logic [PROTO_W-1:0]  PROTO_NUM_ICMP = 8'd1;
    localparam logic [APB_AW-1:0]   INBOUND_ADDR  = {REG_INBOUND, 2'b00};
    localparam logic [APB_AW-1:0]   OUTBOUND_ADDR = {REG_OUTBOUND, 2'b00};

    typedef struct {
        logic [REQ_W-1:0]    kind;
        logic                dir;
        logic [IDX_W-1:0]    index;
        logic [PROTO_W-1:0]  proto;
        bounds_t             tuple;
        logic [RPROTO_W-1:0] rproto;
        logic                drops;
        logic                enabled;
    } request_t;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                failures;
    int                pending_verdicts;
    int                offered;
    int                in_count;
    int                out_count;
    bit                steady;
    bit                hold_long;
    bit                sender_idles;
    bounds_t           low_shadow  [2][RULES];
    bounds_t           high_shadow [2][RULES];
    bit                low_written [2][RULES];

    fmc_req_if req_bus ();
    fmc_rsp_if rsp_bus ();

    first_match_packet_rule_classifier u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_bus),
        .rsp     (rsp_bus)
    );

    verdict_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .req              (req_bus),
        .rsp              (rsp_bus),
        .failures         (failures),
        .pending_verdicts (pending_verdicts)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] draw_between(input logic [31:0] lo, hi);
        logic [63:0] span;
        logic [63:0] draw;
        if (lo > hi)
            return $urandom;
        span = {32'd0, hi} - {32'd0, lo} + 64'd1;
        draw = {$urandom, $urandom} % span;
        return lo + draw[31:0];
    endfunction

    function automatic bounds_t random_tuple();
        bounds_t t;
        t.src_addr = $urandom;
        t.dst_addr = $urandom;
        t.src_l4   = PORT_W'($urandom);
        t.dst_l4   = PORT_W'($urandom);
        case ($urandom_range(0, 15))
            0: t = '0;
            1: t = '1;
            default: ;
        endcase
        return t;
    endfunction

    function automatic logic [PROTO_W-1:0] packet_protocol();
        case ($urandom_range(0, 11))
            0: return PROTO_W'($urandom_range(0, 255));
            1: return PROTO_NUM_ICMP;
            2, 3, 4, 5, 6: return PROTO_NUM_TCP;
            default: return PROTO_NUM_UDP;
        endcase
    endfunction

    function automatic int scan_window(input logic dir);
        int c;
        c = dir ? out_count : in_count;
        return (c == 0 || c > RULES) ? RULES : c;
    endfunction

    task automatic draw_range(input int bits, output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] top_value;
        logic [31:0] span;
        top_value = (bits == ADDR_W) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        case ($urandom_range(0, 9))
            0:
            begin
                lo = '0;
                hi = top_value;
            end
            1:
            begin
                lo = $urandom & top_value;
                hi = lo;
            end
            2:
            begin
                // inverted range
                lo = ($urandom & top_value) | 32'd1;
                hi = lo - 32'd1;
            end
            default:
            begin
                lo   = $urandom & top_value;
                span = $urandom & ((32'd1 << $urandom_range(0, bits - 1)) - 32'd1);
                hi   = lo + span;
                if (hi < lo || hi > top_value)
                    hi = top_value;
            end
        endcase
    endtask

    task automatic draw_rule(output bounds_t lo, output bounds_t hi);
        logic [31:0] a;
        logic [31:0] b;
        draw_range(ADDR_W, a, b);
        lo.src_addr = a;
        hi.src_addr = b;
        draw_range(ADDR_W, a, b);
        lo.dst_addr = a;
        hi.dst_addr = b;
        draw_range(PORT_W, a, b);
        lo.src_l4 = a[PORT_W-1:0];
        hi.src_l4 = b[PORT_W-1:0];
        draw_range(PORT_W, a, b);
        lo.dst_l4 = a[PORT_W-1:0];
        hi.dst_l4 = b[PORT_W-1:0];
    endtask

    task automatic offer(input request_t r);
        req_bus.valid               <= 1'b1;
        req_bus.req_type            <= r.kind;
        req_bus.direction           <= r.dir;
        req_bus.rule_index          <= r.index;
        req_bus.ip_protocol         <= r.proto;
        req_bus.source_address      <= r.tuple.src_addr;
        req_bus.destination_address <= r.tuple.dst_addr;
        req_bus.source_port         <= r.tuple.src_l4;
        req_bus.destination_port    <= r.tuple.dst_l4;
        req_bus.rule_protocol       <= r.rproto;
        req_bus.rule_drops          <= r.drops;
        req_bus.rule_enabled        <= r.enabled;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        offered++;
        if (sender_idles && !steady && $urandom_range(0, 3) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic write_rule_half(input logic [REQ_W-1:0] kind, input logic dir,
                                   input logic [IDX_W-1:0] index, input bounds_t b,
                                   input logic [RPROTO_W-1:0] rproto, input logic drops,
                                   input logic enabled);
        request_t r;
        r.kind    = kind;
        r.dir     = dir;
        r.index   = index;
        r.proto   = PROTO_W'($urandom);
        r.tuple   = b;
        r.rproto  = rproto;
        r.drops   = drops;
        // a rule goes live only once both halves of its bounds hold data
        r.enabled = enabled && (kind != REQ_WRITE_HIGH || low_written[dir][index]);
        offer(r);
        if (kind == REQ_WRITE_LOW)
        begin
            low_written[dir][index] = 1'b1;
            low_shadow[dir][index]  = b;
        end
        else
            high_shadow[dir][index] = b;
    endtask

    task automatic install_rule(input logic dir, input logic [IDX_W-1:0] index,
                                input bounds_t lo, input bounds_t hi,
                                input logic [RPROTO_W-1:0] rproto, input logic drops,
                                input logic enabled);
        write_rule_half(REQ_WRITE_LOW, dir, index, lo, RPROTO_W'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        write_rule_half(REQ_WRITE_HIGH, dir, index, hi, rproto, drops, enabled);
    endtask

    task automatic classify(input logic dir, input logic [PROTO_W-1:0] proto,
                            input bounds_t tuple);
        request_t r;
        r.kind    = REQ_CLASSIFY;
        r.dir     = dir;
        r.index   = IDX_W'($urandom_range(0, 63));
        r.proto   = proto;
        r.tuple   = tuple;
        r.rproto  = RPROTO_W'($urandom_range(0, 3));
        r.drops   = 1'($urandom_range(0, 1));
        r.enabled = 1'($urandom_range(0, 1));
        offer(r);
    endtask

    task automatic program_counts(input logic [COUNT_W-1:0] inbound,
                                  input logic [COUNT_W-1:0] outbound);
        logic [APB_AW-1:0] addr [2];
        logic [APB_DW-1:0] data [2];
        addr = '{INBOUND_ADDR, OUTBOUND_ADDR};
        data = '{APB_DW'(inbound), APB_DW'(outbound)};
        for (int r = 0; r < 2; r++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr[r];
            pwdata  <= data[r];
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (pready !== 1'b1);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        in_count  = inbound;
        out_count = outbound;
    endtask

    task automatic retune(input logic [COUNT_W-1:0] inbound,
                          input logic [COUNT_W-1:0] outbound);
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts != 0);
        // rule writes may still sit in the command queue
        repeat (SETTLE_CYCLES) @(posedge clk);
        program_counts(inbound, outbound);
    endtask

    task automatic rule_scene();
        logic                dir;
        int                  window;
        int                  chosen[$];
        int                  index;
        int                  pick;
        bounds_t             lo;
        bounds_t             hi;
        bounds_t             tuple;
        logic [RPROTO_W-1:0] rproto;
        logic [PROTO_W-1:0]  proto;
        dir    = 1'($urandom_range(0, 1));
        window = scan_window(dir);
        repeat ($urandom_range(1, 4))
        begin
            index = $urandom_range(0, window - 1);
            draw_rule(lo, hi);
            rproto = ($urandom_range(0, 9) == 0) ? RULE_NEVER : RPROTO_W'($urandom_range(0, 2));
            install_rule(dir, IDX_W'(index), lo, hi, rproto, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 7) != 0);
            chosen.push_back(index);
        end
        repeat ($urandom_range(2, 6))
        begin
            pick = chosen[$urandom_range(0, chosen.size() - 1)];
            if ($urandom_range(0, 9) < 7)
            begin
                lo = low_shadow[dir][pick];
                hi = high_shadow[dir][pick];
                tuple.src_addr = draw_between(lo.src_addr, hi.src_addr);
                tuple.dst_addr = draw_between(lo.dst_addr, hi.dst_addr);
                tuple.src_l4   = PORT_W'(draw_between({16'd0, lo.src_l4}, {16'd0, hi.src_l4}));
                tuple.dst_l4   = PORT_W'(draw_between({16'd0, lo.dst_l4}, {16'd0, hi.dst_l4}));
            end
            else
                tuple = random_tuple();
            proto = packet_protocol();
            classify(dir, proto, tuple);
        end
    endtask

    task automatic noise_item();
        request_t r;
        bounds_t  lo;
        bounds_t  hi;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                classify(1'($urandom_range(0, 1)), packet_protocol(), random_tuple());
            4, 5, 6:
            begin
                draw_rule(lo, hi);
                write_rule_half(REQ_WRITE_LOW, 1'($urandom_range(0, 1)),
                                IDX_W'($urandom_range(0, 63)),
                                lo, RPROTO_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
            end
            7, 8:
            begin
                draw_rule(lo, hi);
                write_rule_half(REQ_WRITE_HIGH, 1'($urandom_range(0, 1)),
                                IDX_W'($urandom_range(0, 63)),
                                hi, RPROTO_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
            end
            default:
            begin
                r.kind    = REQ_RESERVED;
                r.dir     = 1'($urandom_range(0, 1));
                r.index   = IDX_W'($urandom_range(0, 63));
                r.proto   = packet_protocol();
                r.tuple   = random_tuple();
                r.rproto  = RPROTO_W'($urandom_range(0, 3));
                r.drops   = 1'($urandom_range(0, 1));
                r.enabled = 1'($urandom_range(0, 1));
                offer(r);
            end
        endcase
    endtask

    // verdict receiver
    initial
    begin
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (steady)
            begin
                rsp_bus.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8)) @(posedge clk);
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    initial
    begin
        bounds_t            point;
        bounds_t            near;
        request_t           odd;
        int                 phase;
        int                 phase_start;
        logic [COUNT_W-1:0] inbound_plan  [6];
        logic [COUNT_W-1:0] outbound_plan [6];

        inbound_plan  = '{7'd64, 7'd5, 7'd0, 7'd127, 7'd1, 7'd40};
        outbound_plan = '{7'd64, 7'd0, 7'd64, 7'd20, 7'd1, 7'd127};

        psel                        <= 1'b0;
        penable                     <= 1'b0;
        pwrite                      <= 1'b0;
        paddr                       <= '0;
        pwdata                      <= '0;
        req_bus.valid               <= 1'b0;
        req_bus.req_type            <= REQ_CLASSIFY;
        req_bus.direction           <= DIR_INBOUND;
        req_bus.rule_index          <= '0;
        req_bus.ip_protocol         <= '0;
        req_bus.source_address      <= '0;
        req_bus.destination_address <= '0;
        req_bus.source_port         <= '0;
        req_bus.destination_port    <= '0;
        req_bus.rule_protocol       <= RULE_ANY;
        req_bus.rule_drops          <= 1'b0;
        req_bus.rule_enabled        <= 1'b0;
        sender_idles = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty tables and non tcp/udp traffic
        classify(DIR_INBOUND, PROTO_NUM_TCP, '0);
        classify(DIR_OUTBOUND, PROTO_NUM_UDP, '1);
        classify(DIR_INBOUND, 8'd255, '1);
        classify(DIR_OUTBOUND, 8'd0, '0);

        // outbound count above table size
        retune(7'd64, 7'd127);
        install_rule(DIR_INBOUND, 6'd0, '0, '1, RULE_ANY, 1'b1, 1'b1);
        install_rule(DIR_INBOUND, 6'd1, '0, '1, RULE_NEVER, 1'b0, 1'b1);
        install_rule(DIR_OUTBOUND, 6'd62, '1, '0, RULE_ANY, 1'b1, 1'b1);
        install_rule(DIR_OUTBOUND, 6'd63, '0, '1, RULE_UDP, 1'b0, 1'b1);
        classify(DIR_INBOUND, PROTO_NUM_TCP, '1);
        classify(DIR_INBOUND, PROTO_NUM_UDP, '0);
        classify(DIR_OUTBOUND, PROTO_NUM_UDP, random_tuple());
        classify(DIR_OUTBOUND, PROTO_NUM_TCP, random_tuple());

        point = {32'hC0A8_0001, 32'h0A00_00FE, 16'd443, 16'd8080};
        near  = point;
        near.dst_l4 = point.dst_l4 + 16'd1;
        install_rule(DIR_INBOUND, 6'd0, '0, '1, RULE_ANY, 1'b1, 1'b0);
        install_rule(DIR_INBOUND, 6'd2, point, point, RULE_TCP, 1'b1, 1'b1);
        classify(DIR_INBOUND, PROTO_NUM_TCP, point);
        classify(DIR_INBOUND, PROTO_NUM_TCP, near);
        odd.kind    = REQ_RESERVED;
        odd.dir     = DIR_OUTBOUND;
        odd.index   = '1;
        odd.proto   = '1;
        odd.tuple   = '1;
        odd.rproto  = RULE_NEVER;
        odd.drops   = 1'b1;
        odd.enabled = 1'b1;
        offer(odd);
        classify(DIR_INBOUND, PROTO_NUM_UDP, point);

        phase       = 0;
        phase_start = offered;
        while (offered < TOTAL_ITEMS)
        begin
            if (offered - phase_start >= PHASE_ITEMS)
            begin
                phase++;
                if (phase <= 6)
                    retune(inbound_plan[phase-1], outbound_plan[phase-1]);
                else
                    retune(COUNT_W'($urandom_range(0, 127)),
                           COUNT_W'($urandom_range(0, 127)));
                phase_start = offered;
                if (phase == 2)
                    hold_long = 1'b1;
            end
            steady       = (offered >= TOTAL_ITEMS - QUIET_ITEMS);
            sender_idles = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) != 0)
                rule_scene();
            else
                noise_item();
        end
        req_bus.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_verdicts != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
